/* rtl/core/mesq_pkg.sv */
// ----------------------------------------------------------------------------
// mesq_pkg
// Shared widths, register codes and types for the largest free square scanner.
// ----------------------------------------------------------------------------
package mesq_pkg;

    // map limits
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // field widths
    localparam int SIZE_W     = 11;
    localparam int IDX_W      = 10;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int OUT_DATA_W = 32;
    localparam int PAD_W      = OUT_DATA_W - SIZE_W - 2 * IDX_W;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int LEVEL_W    = FIFO_AW + 1;

    // reset values of the registers
    localparam logic [SIZE_W-1:0] ROW_COUNT_RST = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] COL_COUNT_RST = SIZE_W'(1);
    localparam logic [CHAR_W-1:0] OBSTACLE_RST  = CHAR_W'(111);

    localparam logic [SIZE_W-1:0] MAX_COLS_W = SIZE_W'(MAX_COLS);
    localparam logic [SIZE_W-1:0] MAX_ROWS_W = SIZE_W'(MAX_ROWS);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1,
        REG_OBSTACLE  = 2'd2
    } cfg_reg_t;

    // one result, sq_side in the lowest bits
    typedef struct packed {
        logic [IDX_W-1:0]  left_col;
        logic [IDX_W-1:0]  top_row;
        logic [SIZE_W-1:0] sq_side;
    } result_t;

    // control of one cell on its way from the accept cycle to the score cycle
    typedef struct packed {
        logic             obstacle;
        logic             border;
        logic             last;
        logic             fwd;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } cell_ctl_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [SIZE_W-1:0] eff_count(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/core/mesq_line_ram.sv */
// ----------------------------------------------------------------------------
// mesq_line_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mesq_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/mesq_result_fifo.sv */
// ----------------------------------------------------------------------------
// mesq_result_fifo
// Small queue that holds finished results until the output side takes them.
// ----------------------------------------------------------------------------
module mesq_result_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  mesq_pkg::result_t            push_data,
    input  logic                         pop,
    output logic                         out_valid,
    output mesq_pkg::result_t            out_data,
    output logic [mesq_pkg::LEVEL_W-1:0] level
);

    mesq_pkg::result_t                    slot_reg [mesq_pkg::FIFO_DEPTH];
    logic [mesq_pkg::FIFO_AW-1:0]         wr_ptr_reg;
    logic [mesq_pkg::FIFO_AW-1:0]         wr_ptr_next;
    logic [mesq_pkg::FIFO_AW-1:0]         rd_ptr_reg;
    logic [mesq_pkg::FIFO_AW-1:0]         rd_ptr_next;
    logic [mesq_pkg::LEVEL_W-1:0]         level_reg;
    logic [mesq_pkg::LEVEL_W-1:0]         level_next;
    logic                                 do_pop;

    assign do_pop = pop && (level_reg != '0);

    // pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // result slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (level_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign level     = level_reg;

endmodule

/* rtl/core/max_empty_square_scan_core.sv */
// ----------------------------------------------------------------------------
// max_empty_square_scan_core
// Largest free square in a character map, scored cell by cell over one line
// of scores held in a RAM.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata[7:0] cell_req
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata[10:0] sq_side,
//                                             [20:11] top_row, [30:21] left_col
//  cfg      in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one cell per cycle while s_axis_tready is high: the line RAM read is issued
// in the accept cycle and the score is written back in the next; the result of
// a map goes to the result queue, whose level register drives m_axis_tvalid.
// reset clears counters, best square and the result queue; the line RAM is not
// cleared, the first row of every map writes it before it is read.
// s_axis_tready drops only while the four-entry result queue could overflow.
// ----------------------------------------------------------------------------
module max_empty_square_scan_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mesq_pkg::CHAR_W-1:0]       s_axis_tdata,  // cell_req
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sq_side, top_row, left_col, zero pad
    output logic [mesq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mesq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mesq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SW = mesq_pkg::SIZE_W;
    localparam int IW = mesq_pkg::IDX_W;

    // configuration registers
    logic [SW-1:0]               row_count_reg;
    logic [SW-1:0]               col_count_reg;
    logic [mesq_pkg::CHAR_W-1:0] obstacle_reg;

    // position counters
    logic [IW-1:0] row_reg;
    logic [IW-1:0] row_next;
    logic [IW-1:0] col_reg;
    logic [IW-1:0] col_next;

    // accept stage
    logic          in_fire;
    logic [SW-1:0] rows;
    logic [SW-1:0] cols;
    logic          col_wrap;
    logic [SW-1:0] row_b;
    logic [IW-1:0] row_a;
    logic [IW-1:0] col_a;
    logic [SW-1:0] col_inc;
    logic          is_last;
    mesq_pkg::cell_ctl_t ctl_next;

    // score stage
    logic                s1_valid_reg;
    mesq_pkg::cell_ctl_t s1_reg;
    logic [SW-1:0]       rd_data;
    logic [SW-1:0]       fwd_data_reg;
    logic [SW-1:0]       up;
    logic [SW-1:0]       min_a;
    logic [SW-1:0]       min3;
    logic [SW-1:0]       score;
    logic [SW-1:0]       left_reg;
    logic [SW-1:0]       left_next;
    logic [SW-1:0]       diag_reg;
    logic [SW-1:0]       diag_next;

    // best square
    logic          better;
    logic [SW-1:0] best_size_reg;
    logic [SW-1:0] best_size_next;
    logic [IW-1:0] best_top_reg;
    logic [IW-1:0] best_top_next;
    logic [IW-1:0] best_left_reg;
    logic [IW-1:0] best_left_next;
    logic [SW-1:0] cand_size;
    logic [IW-1:0] cand_top;
    logic [IW-1:0] cand_left;

    // result queue
    logic                             push;
    mesq_pkg::result_t                push_data;
    mesq_pkg::result_t                out_data;
    logic [mesq_pkg::LEVEL_W-1:0]     level;
    logic [mesq_pkg::LEVEL_W:0]       pending;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= mesq_pkg::ROW_COUNT_RST;
            col_count_reg <= mesq_pkg::COL_COUNT_RST;
            obstacle_reg  <= mesq_pkg::OBSTACLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (mesq_pkg::cfg_reg_t'(cfg_index))
                mesq_pkg::REG_ROW_COUNT: row_count_reg <= cfg_data;
                mesq_pkg::REG_COL_COUNT: col_count_reg <= cfg_data;
                mesq_pkg::REG_OBSTACLE:  obstacle_reg  <= cfg_data[mesq_pkg::CHAR_W-1:0];
                default:                 ;
            endcase
        end
    end

    // input flow control: room in the queue for everything in flight
    assign pending       = {1'b0, level} + {{mesq_pkg::LEVEL_W{1'b0}},
                                            (s1_valid_reg && s1_reg.last)};
    assign s_axis_tready = (pending < (mesq_pkg::LEVEL_W + 1)'(mesq_pkg::FIFO_DEPTH));
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // position of the accepted cell and of the next one
    always_comb
    begin
        rows     = mesq_pkg::eff_count(row_count_reg, mesq_pkg::MAX_ROWS_W);
        cols     = mesq_pkg::eff_count(col_count_reg, mesq_pkg::MAX_COLS_W);
        col_wrap = ({1'b0, col_reg} >= cols);
        col_a    = col_wrap ? '0 : col_reg;
        row_b    = col_wrap ? ({1'b0, row_reg} + 1'b1) : {1'b0, row_reg};
        row_a    = (row_b >= rows) ? '0 : row_b[IW-1:0];
        is_last  = ({1'b0, row_a} == rows - 1'b1) && ({1'b0, col_a} == cols - 1'b1);
        col_inc  = {1'b0, col_a} + 1'b1;

        row_next = row_reg;
        col_next = col_reg;
        if (in_fire)
        begin
            if (is_last)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (col_inc >= cols)
            begin
                row_next = row_a + 1'b1;
                col_next = '0;
            end
            else
            begin
                row_next = row_a;
                col_next = col_inc[IW-1:0];
            end
        end

        ctl_next.obstacle = (s_axis_tdata == obstacle_reg);
        ctl_next.border   = (row_a == '0) || (col_a == '0);
        ctl_next.last     = is_last;
        ctl_next.fwd      = s1_valid_reg && (s1_reg.col == col_a);
        ctl_next.row      = row_a;
        ctl_next.col      = col_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= ctl_next;
        end
        if (s1_valid_reg)
        begin
            fwd_data_reg <= score;
        end
    end

    // line of scores
    mesq_line_ram #(
        .DEPTH (mesq_pkg::MAX_COLS),
        .WIDTH (SW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_reg.col),
        .wr_data (score),
        .rd_en   (in_fire),
        .rd_addr (col_a),
        .rd_data (rd_data)
    );

    // score of the cell, the write in flight is forwarded when it hits
    always_comb
    begin
        up    = s1_reg.fwd ? fwd_data_reg : rd_data;
        min_a = (up < diag_reg) ? up : diag_reg;
        min3  = (left_reg < min_a) ? left_reg : min_a;
        if (s1_reg.obstacle)
        begin
            score = '0;
        end
        else if (s1_reg.border)
        begin
            score = SW'(1);
        end
        else
        begin
            score = min3 + 1'b1;
        end
    end

    // best square and neighbour scores
    always_comb
    begin
        better    = (score > best_size_reg);
        cand_size = better ? score : best_size_reg;
        cand_top  = better ? IW'({1'b0, s1_reg.row} + 1'b1 - score) : best_top_reg;
        cand_left = better ? IW'({1'b0, s1_reg.col} + 1'b1 - score) : best_left_reg;

        left_next      = left_reg;
        diag_next      = diag_reg;
        best_size_next = best_size_reg;
        best_top_next  = best_top_reg;
        best_left_next = best_left_reg;
        if (s1_valid_reg)
        begin
            if (s1_reg.last)
            begin
                left_next      = '0;
                diag_next      = '0;
                best_size_next = '0;
                best_top_next  = '0;
                best_left_next = '0;
            end
            else
            begin
                left_next      = score;
                diag_next      = up;
                best_size_next = cand_size;
                best_top_next  = cand_top;
                best_left_next = cand_left;
            end
        end

        push               = s1_valid_reg && s1_reg.last;
        push_data.sq_side  = cand_size;
        push_data.top_row  = cand_top;
        push_data.left_col = cand_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_top_reg  <= '0;
            best_left_reg <= '0;
        end
        else
        begin
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            best_size_reg <= best_size_next;
            best_top_reg  <= best_top_next;
            best_left_reg <= best_left_next;
        end
    end

    // output queue
    mesq_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data),
        .level     (level)
    );

    assign m_axis_tdata = {{mesq_pkg::PAD_W{1'b0}}, out_data};

    // forwarding only ever refers to a write issued in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.fwd |-> $past(s1_valid_reg))
        else $error("forward flag without a write in flight");

    // the queue is never pushed while full, unless m_axis_tready pops it in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level < mesq_pkg::LEVEL_W'(mesq_pkg::FIFO_DEPTH)) || m_axis_tready)
        else $error("result pushed into a full queue");

    // the last cell of a map gives a push into the result queue in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_last |=> push)
        else $error("last cell gave no result");

    // within a map the best square only grows
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_reg.last |=> best_size_reg >= $past(best_size_reg))
        else $error("best square shrank within a map");

endmodule

/* verif/tb_max_empty_square_scan_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_empty_square_scan_core
// Self-checking bench for the largest free square scanner. Maps are streamed
// in cell by cell under several map shapes and obstacle bytes. A scoring
// model in the scoreboard class predicts size, top row and left column of
// every map. Each result transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_max_empty_square_scan_core;

    localparam int SW = mesq_pkg::SIZE_W;
    localparam int IW = mesq_pkg::IDX_W;
    localparam int CW = mesq_pkg::CHAR_W;
    localparam int AW = mesq_pkg::CFG_IDX_W;
    localparam int DW = mesq_pkg::CFG_DATA_W;
    localparam int OW = mesq_pkg::OUT_DATA_W;

    // index with no register behind it, writes to it are ignored
    localparam logic [AW-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int RES_W = SW + 2 * IW;

    // scoring model of the scanner plus the queue of predicted squares
    class square_checker;
        logic [SW-1:0]     row_cnt;
        logic [SW-1:0]     col_cnt;
        logic [CW-1:0]     obst;
        logic [SW-1:0]     line_sc [mesq_pkg::MAX_COLS];
        logic [SW-1:0]     left_sc;
        logic [SW-1:0]     diag_sc;
        int unsigned       row_pos;
        int unsigned       col_pos;
        logic [SW-1:0]     best_size;
        int unsigned       best_top;
        int unsigned       best_left;
        mesq_pkg::result_t expected_squares [$];
        int unsigned       maps_done;
        int unsigned       err_count;

        function new();
            row_cnt = mesq_pkg::ROW_COUNT_RST;
            col_cnt = mesq_pkg::COL_COUNT_RST;
            obst = mesq_pkg::OBSTACLE_RST;
            foreach (line_sc[i])
                line_sc[i] = '0;
            maps_done = 0;
            err_count = 0;
            clear_map();
        endfunction

        function void clear_map();
            left_sc = '0;
            diag_sc = '0;
            row_pos = 0;
            col_pos = 0;
            best_size = '0;
            best_top = 0;
            best_left = 0;
        endfunction

        // zero acts as one, above the limit acts as the limit
        function int unsigned clamp_count(logic [SW-1:0] v, int unsigned lim);
            if (v == '0)
                return 1;
            return (v > lim) ? lim : v;
        endfunction

        function void write_reg(logic [AW-1:0] idx, logic [DW-1:0] data);
            case (idx)
                mesq_pkg::REG_ROW_COUNT: row_cnt = data;
                mesq_pkg::REG_COL_COUNT: col_cnt = data;
                mesq_pkg::REG_OBSTACLE:  obst = data[CW-1:0];
                default: ;
            endcase
        endfunction

        // score one accepted cell, predict a square at the end of a map
        function void note_cell(logic [CW-1:0] ch);
            int unsigned       rows;
            int unsigned       cols;
            logic [SW-1:0]     up;
            logic [SW-1:0]     score;
            logic [SW-1:0]     m;
            mesq_pkg::result_t r;
            rows = clamp_count(row_cnt, mesq_pkg::MAX_ROWS);
            cols = clamp_count(col_cnt, mesq_pkg::MAX_COLS);
            // counts may have shrunk since the last cell
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= rows)
                row_pos = 0;
            up = line_sc[col_pos];
            if (ch == obst)
                score = '0;
            else if (row_pos == 0 || col_pos == 0)
                score = SW'(1);
            else
            begin
                m = diag_sc;
                if (up < m)
                    m = up;
                if (left_sc < m)
                    m = left_sc;
                score = m + SW'(1);
            end
            diag_sc = up;
            left_sc = score;
            line_sc[col_pos] = score;
            // only a strictly larger square replaces the best
            if (score > best_size)
            begin
                best_size = score;
                best_top = row_pos + 1 - score;
                best_left = col_pos + 1 - score;
            end
            if (row_pos == rows - 1 && col_pos == cols - 1)
            begin
                r.sq_side = best_size;
                r.top_row = (best_size != '0) ? IW'(best_top) : '0;
                r.left_col = (best_size != '0) ? IW'(best_left) : '0;
                expected_squares.push_back(r);
                maps_done++;
                clear_map();
                return;
            end
            col_pos++;
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos++;
                left_sc = '0;
                diag_sc = '0;
            end
        endfunction

        task report(string msg);
            err_count++;
            if (err_count <= 100)
                $display("mismatch: %s", msg);
        endtask

        task check_square(logic [OW-1:0] tdata);
            mesq_pkg::result_t got;
            mesq_pkg::result_t want;
            got = tdata[RES_W-1:0];
            if (expected_squares.size() == 0)
            begin
                report($sformatf("unexpected result size %0d top %0d left %0d",
                                 got.sq_side, got.top_row, got.left_col));
                return;
            end
            want = expected_squares.pop_front();
            if (got.sq_side != want.sq_side)
                report($sformatf("sq_side %0d, predicted %0d",
                                 got.sq_side, want.sq_side));
            if (got.top_row != want.top_row)
                report($sformatf("top_row %0d, predicted %0d", got.top_row, want.top_row));
            if (got.left_col != want.left_col)
                report($sformatf("left_col %0d, predicted %0d", got.left_col, want.left_col));
            if ((tdata >> RES_W) != '0)
                report($sformatf("pad bits not zero in %h", tdata));
        endtask
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [CW-1:0] s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [OW-1:0] m_axis_tdata;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [AW-1:0] cfg_index = '0;
    logic [DW-1:0] cfg_data = '0;

    square_checker sb = new();
    int unsigned   tx_pct = 0;
    int unsigned   rx_pct = 0;
    int unsigned   cells_sent = 0;

    max_empty_square_scan_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // result side: check each transfer, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_square(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= rx_pct);
    end

    // one cell transfer, with random gaps ahead of it
    task automatic send_cell(input logic [CW-1:0] ch);
        while ($urandom_range(99) < tx_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ch;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_cell(ch);
        cells_sent++;
    endtask

    // stop the cell stream and let every predicted square drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_squares.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [AW-1:0] idx,
                             input logic [DW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // new map shape, upper data bits of the obstacle write are don't-care
    task automatic set_map(input logic [DW-1:0] rows,
                           input logic [DW-1:0] cols,
                           input logic [CW-1:0] obst);
        settle();
        write_reg(mesq_pkg::REG_ROW_COUNT, rows);
        write_reg(mesq_pkg::REG_COL_COUNT, cols);
        write_reg(mesq_pkg::REG_OBSTACLE, {3'($urandom), obst});
    endtask

    function automatic logic [CW-1:0] pick_cell(logic [CW-1:0] obst,
                                                 int unsigned density);
        if ($urandom_range(99) < density)
            return obst;
        return CW'($urandom);
    endfunction

    // complete maps with random content, now and then a row count change mid-map
    task automatic run_random(input int unsigned n_cells);
        int unsigned   stop_at;
        int unsigned   total;
        int unsigned   k;
        int unsigned   density;
        int unsigned   start_done;
        logic [DW-1:0] rows;
        logic [DW-1:0] cols;
        logic [CW-1:0] obst;
        stop_at = cells_sent + n_cells;
        while (cells_sent < stop_at)
        begin
            rows = DW'($urandom_range(0, 7));
            cols = ($urandom_range(9) == 0) ? DW'($urandom_range(10, 32))
                                            : DW'($urandom_range(0, 9));
            obst = CW'($urandom);
            density = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 60);
            if ($urandom_range(15) == 0)
            begin
                settle();
                write_reg(REG_SPARE, DW'($urandom));
            end
            set_map(rows, cols, obst);
            total = sb.clamp_count(rows, mesq_pkg::MAX_ROWS)
                  * sb.clamp_count(cols, mesq_pkg::MAX_COLS);
            start_done = sb.maps_done;
            if (total > 1 && $urandom_range(99) < 15)
            begin
                // broken map: stop part way and move the row count
                k = $urandom_range(1, total - 1);
                repeat (k) send_cell(pick_cell(obst, density));
                settle();
                write_reg(mesq_pkg::REG_ROW_COUNT, DW'($urandom_range(0, 9)));
                while (sb.maps_done == start_done)
                    send_cell(pick_cell(obst, density));
            end
            else
            begin
                repeat (total) send_cell(pick_cell(obst, density));
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register reset values: one cell map, obstacle then free
        send_cell(mesq_pkg::OBSTACLE_RST);
        send_cell(8'h2e);

        // zero counts act as one, obstacle byte zero
        set_map(11'd0, 11'd0, 8'h00);
        send_cell(8'h00);
        send_cell(8'hff);

        // write to the unused index, then a fully free 3x3 map
        settle();
        write_reg(REG_SPARE, 11'h7ff);
        set_map(11'd3, 11'd3, 8'hff);
        send_cell(8'h00);
        send_cell(8'h55);
        send_cell(8'haa);
        send_cell(8'hfe);
        send_cell(8'h01);
        send_cell(8'h7f);
        send_cell(8'h80);
        send_cell(8'h2e);
        send_cell(8'h6f);

        // row count shrinks mid-map: restart at row 0, best kept
        set_map(11'd3, 11'd2, 8'h23);
        repeat (4) send_cell(8'h2e);
        settle();
        write_reg(mesq_pkg::REG_ROW_COUNT, 11'd2);
        send_cell(8'h23);
        send_cell(8'h2e);
        send_cell(8'h2e);
        send_cell(8'h2e);

        // column count shrinks mid-map: the cell ends the map
        set_map(11'd2, 11'd3, 8'h6f);
        repeat (4) send_cell(8'h2e);
        settle();
        write_reg(mesq_pkg::REG_COL_COUNT, 11'd2);
        send_cell(8'h2e);

        // widest row, cut short by a column count shrink
        tx_pct = 37;
        rx_pct = 37;
        set_map(11'd2, 11'd1024, 8'h6f);
        repeat (40) send_cell(8'h2e);
        settle();
        write_reg(mesq_pkg::REG_COL_COUNT, 11'd20);
        repeat (20) send_cell(8'h2e);

        // row count above the limit, ended by a smaller row count
        set_map(11'd2047, 11'd1, 8'h31);
        repeat (30) send_cell(8'hb1);
        settle();
        write_reg(mesq_pkg::REG_ROW_COUNT, 11'd31);
        send_cell(8'hb1);

        // random maps under each idling pattern
        for (int mode = 0; mode < 4; mode++)
        begin
            settle();
            case (mode)
                0:
                begin
                    tx_pct = 0;
                    rx_pct = 0;
                end
                1:
                begin
                    tx_pct = 47;
                    rx_pct = 0;
                end
                2:
                begin
                    tx_pct = 0;
                    rx_pct = 47;
                end
                default:
                begin
                    tx_pct = 37;
                    rx_pct = 37;
                end
            endcase
            run_random(190);
        end

        // drain and let the pipeline run dry
        settle();
        if (sb.expected_squares.size() != 0)
            sb.report($sformatf("%0d predicted squares never arrived",
                                sb.expected_squares.size()));
        if (sb.err_count == 0)
            $display("tb_max_empty_square_scan_core OK");
        else
            $display("tb_max_empty_square_scan_core NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("tb_max_empty_square_scan_core NOT OK");
        $finish;
    end

endmodule
